### rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int RAW_W   = 20;
    localparam int OUT_W   = 32;
    localparam int WIDE_W  = 64;
    localparam int DEN_W   = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_OFFSET  = 3'd0,
        REG_TEMP_LINEAR  = 3'd1,
        REG_TEMP_SQUARE  = 3'd2,
        REG_PRESS_SCALE  = 3'd3,
        REG_PRESS_2_TO_5 = 3'd4,
        REG_PRESS_6_TO_9 = 3'd5
    } bpc_reg_t;

    localparam logic signed [33:0] FINE_BIAS     = 34'sd128000;
    localparam logic [11:0]        PRESS_MUL     = 12'd3125;
    localparam logic [20:0]        PRESS_FULL    = 21'd1048576;
    localparam logic [31:0]        ROUND_HALF    = 32'd128;
    localparam logic [63:0]        SCALE_ONE     = 64'd1 << 47;

    typedef struct packed {
        logic [OUT_W-1:0] temp;
        logic [OUT_W-1:0] fine;
        logic             invalid;
    } bpc_side_t;

endpackage

`default_nettype wire

### rtl/barometer_temp_pressure_compensation.sv
`timescale 1ns / 1ps
`default_nettype none

// barometer compensation, fully pipelined
// input: raw_temperature and raw_pressure are taken at a clock edge with start
//   high and busy low; busy stays low, so a new beat can enter every cycle
// output: done is high for one cycle with temperature_centi, fine_temperature,
//   pressure_q24_8 and pressure_invalid; there is no back-pressure
// throughput: one result per cycle sustained; the 64-step signed divider
//   (one quotient bit per stage) sets most of the pipeline depth, the
//   multiply chain around it the rest
// configuration: cfg_valid / cfg_ready write channel, cfg_ready always high;
//   cfg_index picks the coefficient register, indexes above five are ignored;
//   write only while no beat is in flight
// reset: rst_n clears all coefficients to zero and empties the pipeline
// a zero pressure denominator gives pressure_q24_8 of zero with
//   pressure_invalid set; temperatures are still valid
module barometer_temp_pressure_compensation (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [bpc_pkg::RAW_W-1:0]        raw_temperature,
    input  wire logic [bpc_pkg::RAW_W-1:0]        raw_pressure,
    output logic                                  done,
    output logic signed [bpc_pkg::OUT_W-1:0]      temperature_centi,
    output logic signed [bpc_pkg::OUT_W-1:0]      fine_temperature,
    output logic [bpc_pkg::OUT_W-1:0]             pressure_q24_8,
    output logic                                  pressure_invalid,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::WIDE_W-1:0]       cfg_data
);
    import bpc_pkg::*;

    // coefficient registers
    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [63:0] p25_reg, p69_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            p1_reg  <= '0;
            p25_reg <= '0;
            p69_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEMP_OFFSET:  t1_reg  <= cfg_data[15:0];
                REG_TEMP_LINEAR:  t2_reg  <= cfg_data[15:0];
                REG_TEMP_SQUARE:  t3_reg  <= cfg_data[15:0];
                REG_PRESS_SCALE:  p1_reg  <= cfg_data[15:0];
                REG_PRESS_2_TO_5: p25_reg <= cfg_data;
                REG_PRESS_6_TO_9: p69_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [16:0] p1;
    assign t2 = $signed(t2_reg);
    assign t3 = $signed(t3_reg);
    assign p1 = $signed({1'b0, p1_reg});
    assign p2 = $signed(p25_reg[15:0]);
    assign p3 = $signed(p25_reg[31:16]);
    assign p4 = $signed(p25_reg[47:32]);
    assign p5 = $signed(p25_reg[63:48]);
    assign p6 = $signed(p69_reg[15:0]);
    assign p7 = $signed(p69_reg[31:16]);
    assign p8 = $signed(p69_reg[47:32]);
    assign p9 = $signed(p69_reg[63:48]);

    // valid bits of the stages around the divider
    logic [9:0] vld_reg;
    logic [3:0] post_vld_reg;
    logic       div_vld;
    logic       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            post_vld_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            vld_reg      <= {vld_reg[8:0], start && !busy};
            post_vld_reg <= {post_vld_reg[2:0], div_vld};
            done_reg     <= post_vld_reg[3];
        end
    end

    // stage 0: capture
    logic [RAW_W-1:0] adct_reg;
    logic [RAW_W-1:0] adcp0_reg;

    always_ff @(posedge clk)
    begin
        adct_reg  <= raw_temperature;
        adcp0_reg <= raw_pressure;
    end

    // stage 1: temperature products
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [33:0] lin_full;
    logic signed [33:0] sqr_full;
    logic [31:0]        lin1_reg, dd1_reg;
    logic [RAW_W-1:0]   adcp1_reg;

    always_comb
    begin
        d1       = $signed({1'b0, adct_reg[19:3]}) - $signed({1'b0, t1_reg, 1'b0});
        d2       = $signed({1'b0, adct_reg[19:4]}) - $signed({1'b0, t1_reg});
        lin_full = d1 * t2;
        sqr_full = d2 * d2;
    end

    always_ff @(posedge clk)
    begin
        lin1_reg  <= lin_full[31:0];
        dd1_reg   <= sqr_full[31:0];
        adcp1_reg <= adcp0_reg;
    end

    // stage 2: quadratic term product
    logic signed [47:0] quad_full;
    logic signed [31:0] a2_reg;
    logic [31:0]        bq2_reg;
    logic [RAW_W-1:0]   adcp2_reg;

    always_comb
    begin
        quad_full = ($signed(dd1_reg) >>> 12) * t3;
    end

    always_ff @(posedge clk)
    begin
        a2_reg    <= $signed(lin1_reg) >>> 11;
        bq2_reg   <= quad_full[31:0];
        adcp2_reg <= adcp1_reg;
    end

    // stage 3: fine temperature
    logic signed [31:0] fine3_reg;
    logic [RAW_W-1:0]   adcp3_reg;

    always_ff @(posedge clk)
    begin
        fine3_reg <= a2_reg + ($signed(bq2_reg) >>> 14);
        adcp3_reg <= adcp2_reg;
    end

    // stage 4: centi-degrees and pressure offset
    logic [31:0]        temp_sum;
    logic [31:0]        temp4_reg;
    logic [31:0]        fine4_reg;
    logic signed [33:0] v14_reg;
    logic [RAW_W-1:0]   adcp4_reg;

    always_comb
    begin
        temp_sum = {fine3_reg[29:0], 2'b00} + fine3_reg + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        temp4_reg <= $signed(temp_sum) >>> 8;
        fine4_reg <= fine3_reg;
        v14_reg   <= {{2{fine3_reg[31]}}, fine3_reg} - FINE_BIAS;
        adcp4_reg <= adcp3_reg;
    end

    // stage 5: offset products
    logic signed [67:0] sq_full;
    logic signed [49:0] m5_full, m2_full;
    logic [63:0]        sq5_reg;
    logic signed [49:0] m55_reg, m25_reg;
    logic [31:0]        temp5_reg, fine5_reg;
    logic [RAW_W-1:0]   adcp5_reg;

    always_comb
    begin
        sq_full = v14_reg * v14_reg;
        m5_full = v14_reg * p5;
        m2_full = v14_reg * p2;
    end

    always_ff @(posedge clk)
    begin
        sq5_reg   <= sq_full[63:0];
        m55_reg   <= m5_full;
        m25_reg   <= m2_full;
        temp5_reg <= temp4_reg;
        fine5_reg <= fine4_reg;
        adcp5_reg <= adcp4_reg;
    end

    // stage 6: square times coefficients
    logic signed [79:0] x6_full, x3_full;
    logic [63:0]        x66_reg, x36_reg;
    logic [63:0]        m56_reg, m26_reg;
    logic [31:0]        temp6_reg, fine6_reg;
    logic [RAW_W-1:0]   adcp6_reg;

    always_comb
    begin
        x6_full = $signed(sq5_reg) * p6;
        x3_full = $signed(sq5_reg) * p3;
    end

    always_ff @(posedge clk)
    begin
        x66_reg   <= x6_full[63:0];
        x36_reg   <= x3_full[63:0];
        m56_reg   <= {{14{m55_reg[49]}}, m55_reg} << 17;
        m26_reg   <= {{14{m25_reg[49]}}, m25_reg} << 12;
        temp6_reg <= temp5_reg;
        fine6_reg <= fine5_reg;
        adcp6_reg <= adcp5_reg;
    end

    // stage 7: sums
    logic [63:0]      v27_reg, base7_reg;
    logic [31:0]      temp7_reg, fine7_reg;
    logic [RAW_W-1:0] adcp7_reg;

    always_ff @(posedge clk)
    begin
        v27_reg   <= x66_reg + m56_reg + ({{48{p4[15]}}, p4} << 35);
        base7_reg <= SCALE_ONE + 64'($signed(x36_reg) >>> 8) + m26_reg;
        temp7_reg <= temp6_reg;
        fine7_reg <= fine6_reg;
        adcp7_reg <= adcp6_reg;
    end

    // stage 8: scale product and numerator base
    logic signed [80:0] scl_full;
    logic [63:0]        scl8_reg, pn8_reg;
    logic [31:0]        temp8_reg, fine8_reg;
    logic [20:0]        pres_lin;

    always_comb
    begin
        scl_full = $signed(base7_reg) * p1;
        pres_lin = PRESS_FULL - {1'b0, adcp7_reg};
    end

    always_ff @(posedge clk)
    begin
        scl8_reg  <= scl_full[63:0];
        pn8_reg   <= ({43'd0, pres_lin} << 31) - v27_reg;
        temp8_reg <= temp7_reg;
        fine8_reg <= fine7_reg;
    end

    // stage 9: denominator and scaled numerator
    logic [63:0]     num9_reg;
    logic [DEN_W-1:0] den9_reg;
    bpc_side_t       side9_reg;

    always_ff @(posedge clk)
    begin
        num9_reg          <= pn8_reg * {52'd0, PRESS_MUL};
        den9_reg          <= {scl8_reg[63], scl8_reg[63:33]};
        side9_reg.temp    <= temp8_reg;
        side9_reg.fine    <= fine8_reg;
        side9_reg.invalid <= (scl8_reg[63:33] == 31'd0);
    end

    logic [63:0] quot;
    bpc_side_t   div_side;

    bpc_divider #(
        .NUM_W (WIDE_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[9]),
        .num       (num9_reg),
        .den       (den9_reg),
        .side_in   (side9_reg),
        .out_valid (div_vld),
        .quot      (quot),
        .side_out  (div_side)
    );

    // post 1: split square of scaled pressure, eighth-coefficient term
    logic signed [63:0] ps;
    logic signed [79:0] m8_full;
    logic [63:0]        ll1_reg;
    logic [31:0]        lh1_reg;
    logic [63:0]        m81_reg, pq1_reg;
    bpc_side_t          side1_reg;

    always_comb
    begin
        ps      = $signed(quot) >>> 13;
        m8_full = $signed(quot) * p8;
    end

    always_ff @(posedge clk)
    begin
        ll1_reg   <= ps[31:0] * ps[31:0];
        lh1_reg   <= 32'(ps[63:32] * ps[31:0]);
        m81_reg   <= 64'($signed(m8_full[63:0]) >>> 19);
        pq1_reg   <= quot;
        side1_reg <= div_side;
    end

    // post 2: assemble square
    logic [63:0] ss2_reg, m82_reg, pq2_reg;
    bpc_side_t   side2_reg;

    always_ff @(posedge clk)
    begin
        ss2_reg   <= ll1_reg + {lh1_reg[30:0], 1'b0, 32'd0};
        m82_reg   <= m81_reg;
        pq2_reg   <= pq1_reg;
        side2_reg <= side1_reg;
    end

    // post 3: ninth-coefficient term
    logic signed [79:0] m9_full;
    logic [63:0]        m93_reg, m83_reg, pq3_reg;
    bpc_side_t          side3_reg;

    always_comb
    begin
        m9_full = $signed(ss2_reg) * p9;
    end

    always_ff @(posedge clk)
    begin
        m93_reg   <= m9_full[63:0];
        m83_reg   <= m82_reg;
        pq3_reg   <= pq2_reg;
        side3_reg <= side2_reg;
    end

    // post 4: pressure sum
    logic [63:0] sum4_reg;
    bpc_side_t   side4_reg;

    always_ff @(posedge clk)
    begin
        sum4_reg  <= pq3_reg + 64'($signed(m93_reg) >>> 25) + m83_reg;
        side4_reg <= side3_reg;
    end

    // output registers
    logic [63:0] press_full;
    logic [31:0] temp_out_reg, fine_out_reg, press_out_reg;
    logic        inv_out_reg;

    always_comb
    begin
        press_full = 64'($signed(sum4_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);
    end

    always_ff @(posedge clk)
    begin
        temp_out_reg  <= side4_reg.temp;
        fine_out_reg  <= side4_reg.fine;
        press_out_reg <= side4_reg.invalid ? 32'd0 : press_full[31:0];
        inv_out_reg   <= side4_reg.invalid;
    end

    assign done              = done_reg;
    assign temperature_centi = $signed(temp_out_reg);
    assign fine_temperature  = $signed(fine_out_reg);
    assign pressure_q24_8    = press_out_reg;
    assign pressure_invalid  = inv_out_reg;

endmodule

`default_nettype wire

### rtl/bpc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module bpc_divider #(
    parameter int NUM_W = bpc_pkg::WIDE_W,
    parameter int DEN_W = bpc_pkg::DEN_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [NUM_W-1:0]        num,
    input  wire logic [DEN_W-1:0]        den,
    input  wire bpc_pkg::bpc_side_t      side_in,
    output logic                         out_valid,
    output logic [NUM_W-1:0]             quot,
    output bpc_pkg::bpc_side_t           side_out
);
    import bpc_pkg::*;

    logic [DEN_W-1:0] rem_reg  [0:NUM_W];
    logic [NUM_W-1:0] nq_reg   [0:NUM_W];
    logic [DEN_W-1:0] ad_reg   [0:NUM_W];
    logic             neg_reg  [0:NUM_W];
    bpc_side_t        side_reg [0:NUM_W];
    logic             vld_reg  [0:NUM_W];

    logic             out_vld_reg;
    logic [NUM_W-1:0] quot_reg;
    bpc_side_t        side_out_reg;

    // magnitudes and result sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        nq_reg[0]   <= num[NUM_W-1] ? (~num + 1'b1) : num;
        ad_reg[0]   <= den[DEN_W-1] ? (~den + 1'b1) : den;
        neg_reg[0]  <= num[NUM_W-1] ^ den[DEN_W-1];
        side_reg[0] <= side_in;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic             bit_next;

        always_comb
        begin
            trial = {rem_reg[k], nq_reg[k][NUM_W-1]};
            diff  = trial - {1'b0, ad_reg[k]};
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            nq_reg[k+1]   <= {nq_reg[k][NUM_W-2:0], bit_next};
            ad_reg[k+1]   <= ad_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    // sign fix-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= neg_reg[NUM_W] ? (~nq_reg[NUM_W] + 1'b1) : nq_reg[NUM_W];
        side_out_reg <= side_reg[NUM_W];
    end

    assign out_valid = out_vld_reg;
    assign quot      = quot_reg;
    assign side_out  = side_out_reg;

endmodule

`default_nettype wire

### dv/barometer_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps

module barometer_temp_pressure_compensation_tb;
    import bpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PIPE_DEPTH = 80;

    typedef struct {
        logic signed [OUT_W-1:0] temp_centi;
        logic signed [OUT_W-1:0] fine;
        logic [OUT_W-1:0]        press;
        logic                    invalid;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [RAW_W-1:0] raw_temperature = '0;
    logic [RAW_W-1:0] raw_pressure = '0;
    logic done;
    logic signed [OUT_W-1:0] temperature_centi;
    logic signed [OUT_W-1:0] fine_temperature;
    logic [OUT_W-1:0] pressure_q24_8;
    logic pressure_invalid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIDE_W-1:0] cfg_data = '0;

    logic [15:0] cal_t1;
    shortint     cal_t2;
    shortint     cal_t3;
    logic [15:0] cal_p1;
    logic [63:0] cal_p2_5;
    logic [63:0] cal_p6_9;

    reading_t pending_readings[$];
    int errors = 0;
    int sender_idle_pct = 0;

    barometer_temp_pressure_compensation uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .raw_temperature(raw_temperature),
        .raw_pressure(raw_pressure),
        .done(done),
        .temperature_centi(temperature_centi),
        .fine_temperature(fine_temperature),
        .pressure_q24_8(pressure_q24_8),
        .pressure_invalid(pressure_invalid),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint coef(input logic [63:0] packed_word, input int slot);
        logic [15:0] f;
        f = packed_word[slot*16 +: 16];
        return longint'(shortint'(f));
    endfunction

    function automatic reading_t compensate(input logic [RAW_W-1:0] rt,
                                            input logic [RAW_W-1:0] rp);
        reading_t r;
        int d;
        int a;
        int b;
        int fine;
        longint v1;
        longint v2;
        longint p;
        longint num;
        d = int'(rt >> 3) - (int'(cal_t1) <<< 1);
        a = (d * int'(cal_t2)) >>> 11;
        d = int'(rt >> 4) - int'(cal_t1);
        b = (((d * d) >>> 12) * int'(cal_t3)) >>> 14;
        fine = a + b;
        r.fine = fine;
        r.temp_centi = (fine * 5 + 128) >>> 8;
        v1 = longint'(fine) - longint'(128000);
        v2 = v1 * v1 * coef(cal_p6_9, 0);
        v2 = v2 + ((v1 * coef(cal_p2_5, 3)) <<< 17);
        v2 = v2 + (coef(cal_p2_5, 2) <<< 35);
        v1 = ((v1 * v1 * coef(cal_p2_5, 1)) >>> 8) + ((v1 * coef(cal_p2_5, 0)) <<< 12);
        v1 = (((longint'(1) <<< 47) + v1) * longint'(cal_p1)) >>> 33;
        if (v1 == 0)
        begin
            r.press = '0;
            r.invalid = 1'b1;
        end
        else
        begin
            p = longint'(1048576) - longint'(rp);
            num = ((p <<< 31) - v2) * longint'(3125);
            if (v1 == -1)
                p = -num;
            else
                p = num / v1;
            v1 = (coef(cal_p6_9, 3) * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (coef(cal_p6_9, 2) * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (coef(cal_p6_9, 1) <<< 4);
            r.press = p[31:0];
            r.invalid = 1'b0;
        end
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: temp %0d fine %0d press %h inv %b",
                             temperature_centi, fine_temperature, pressure_q24_8,
                             pressure_invalid);
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (temperature_centi !== exp_r.temp_centi || fine_temperature !== exp_r.fine ||
                    pressure_q24_8 !== exp_r.press || pressure_invalid !== exp_r.invalid)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %0d %h %b got %0d %0d %h %b",
                                 exp_r.temp_centi, exp_r.fine, exp_r.press, exp_r.invalid,
                                 temperature_centi, fine_temperature, pressure_q24_8,
                                 pressure_invalid);
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TEMP_OFFSET:  cal_t1 = val[15:0];
            REG_TEMP_LINEAR:  cal_t2 = shortint'(val[15:0]);
            REG_TEMP_SQUARE:  cal_t3 = shortint'(val[15:0]);
            REG_PRESS_SCALE:  cal_p1 = val[15:0];
            REG_PRESS_2_TO_5: cal_p2_5 = val;
            REG_PRESS_6_TO_9: cal_p6_9 = val;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [15:0] t1, input shortint t2, input shortint t3,
                                    input logic [15:0] p1, input logic [63:0] p2_5,
                                    input logic [63:0] p6_9);
        cfg_write(REG_TEMP_OFFSET, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | t1);
        cfg_write(REG_TEMP_LINEAR, {48'h0, t2});
        cfg_write(REG_TEMP_SQUARE, {48'h0, t3});
        cfg_write(REG_PRESS_SCALE, {48'h0, p1});
        cfg_write(REG_PRESS_2_TO_5, p2_5);
        cfg_write(REG_PRESS_6_TO_9, p6_9);
    endtask

    // one beat; start stays high afterwards unless the sender takes a gap
    task automatic send_reading(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp);
        start <= 1'b1;
        raw_temperature <= rt;
        raw_pressure <= rp;
        do @(posedge clk); while (busy);
        pending_readings.push_back(compensate(rt, rp));
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    function automatic logic [63:0] typical_p2_5();
        return {16'sd140, 16'sd2855, 16'sd3024, -16'sd10685};
    endfunction

    function automatic logic [63:0] typical_p6_9();
        return {16'sd6000, -16'sd14600, 16'sd15500, -16'sd7};
    endfunction

    task automatic test_reset_state();
        cal_t1 = '0; cal_t2 = 0; cal_t3 = 0; cal_p1 = '0; cal_p2_5 = '0; cal_p6_9 = '0;
        send_reading(20'h0, 20'h0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        drain();
    endtask

    task automatic test_typical_readings();
        load_calibration(16'd27504, 16'sd26435, -16'sd1000, 16'd36477,
                         typical_p2_5(), typical_p6_9());
        send_reading(20'd519888, 20'd415148);
        send_reading(20'h0, 20'h0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h0);
        send_reading(20'hAAAAA, 20'h55555);
        send_reading(20'h55555, 20'hAAAAA);
        drain();
        // zero scale gives a zero denominator
        cfg_write(REG_PRESS_SCALE, 64'h0);
        send_reading(20'd519888, 20'd415148);
        drain();
    endtask

    task automatic test_coefficient_extremes();
        load_calibration(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
                         {4{16'h7FFF}}, {4{16'h7FFF}});
        send_reading(20'h0, 20'h0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd1);
        drain();
        load_calibration(16'h0, -16'sh8000, -16'sh8000, 16'h1,
                         {4{16'h8000}}, {4{16'h8000}});
        send_reading(20'h0, 20'h0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h80000, 20'h7FFFF);
        drain();
    endtask

    task automatic test_ignored_index();
        load_calibration(16'd27504, 16'sd26435, -16'sd1000, 16'd36477,
                         typical_p2_5(), typical_p6_9());
        cfg_write(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_SPARE_HI, 64'h0);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd500000, 20'd300000);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int sets, input int per_set);
        logic [63:0] p2_5;
        logic [63:0] p6_9;
        logic [15:0] t1;
        logic [15:0] p1;
        sender_idle_pct = idle_pct;
        for (int s = 0; s < sets; s++)
        begin
            if ($urandom_range(3) == 0)
            begin
                p2_5 = {$urandom, $urandom};
                p6_9 = {$urandom, $urandom};
                t1 = $urandom;
                p1 = ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom);
                load_calibration(t1, shortint'($urandom), shortint'($urandom), p1, p2_5, p6_9);
            end
            else
            begin
                p2_5 = typical_p2_5() ^ {4{16'($urandom_range(255))}};
                p6_9 = typical_p6_9() ^ {4{16'($urandom_range(255))}};
                load_calibration(16'd27504 + 16'($urandom_range(4000)),
                                 shortint'(26435 - $urandom_range(4000)),
                                 shortint'(-1000 + $urandom_range(2000)),
                                 16'd36477 + 16'($urandom_range(4000)), p2_5, p6_9);
            end
            for (int i = 0; i < per_set; i++)
            begin
                if ($urandom_range(1) == 0)
                    send_reading(20'($urandom_range(560000, 440000)),
                                 20'($urandom_range(500000, 250000)));
                else
                    send_reading(20'($urandom), 20'($urandom));
            end
            drain();
        end
        sender_idle_pct = 0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_typical_readings();
        test_coefficient_extremes();
        test_ignored_index();
        test_random_traffic(18, 5, 100);
        test_random_traffic(86, 5, 100);
        test_random_traffic(0, 5, 100);
        if (pending_readings.size() != 0)
            errors++;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/bpc_pkg.sv
rtl/bpc_divider.sv
rtl/barometer_temp_pressure_compensation.sv
dv/barometer_temp_pressure_compensation_tb.sv
